>>> rtl/scs_pkg.sv
// Shared types, constants and elaboration-time tables for the spectral cross-synthesis bin.
package scs_pkg;

  localparam int ANGLE_STEPS = 16;
  localparam int STEPS_USED  = (ANGLE_STEPS > 32) ? 32 : ANGLE_STEPS;

  localparam int POLAR_CELLS = 32;
  localparam int LOG_CELLS   = 24;
  localparam int EXP_CELLS   = 24;
  localparam int PIPE_DEPTH  = 3 + POLAR_CELLS + 2 + LOG_CELLS + 3 + EXP_CELLS + 2 + STEPS_USED;

  localparam int VEC_W = 36;
  localparam int ROT_W = 34;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 31;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_INVERT_MODE      = 2'd0,
    REG_MAG_EXPONENT     = 2'd1,
    REG_DIVIDE_THRESHOLD = 2'd2
  } cfg_reg_t;

  localparam logic [30:0] THRESHOLD_DEFAULT = 31'd6554;
  localparam logic [30:0] THRESHOLD_RESET   = 31'd655;
  localparam logic [13:0] EXPONENT_RESET    = 14'd1024;

  localparam logic [31:0] ATAN_TURNS [0:31] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic signed [31:0] first_real;
    logic signed [31:0] first_imag;
    logic signed [31:0] second_real;
    logic signed [31:0] second_imag;
    logic               edge_bin;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_real;
    logic signed [31:0] out_imag;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic [63:0]             rem1;
    logic [63:0]             root1;
    logic [63:0]             rem2;
    logic [63:0]             root2;
    logic signed [VEC_W-1:0] x1;
    logic signed [VEC_W-1:0] y1;
    logic signed [VEC_W-1:0] x2;
    logic signed [VEC_W-1:0] y2;
    logic [31:0]             ang1;
    logic [31:0]             ang2;
    logic                    zero1;
    logic                    zero2;
  } polar_t;

  typedef struct packed {
    logic [30:0] m1;
    logic [30:0] m2;
    logic [23:0] frac1;
    logic [23:0] frac2;
    logic [4:0]  p1;
    logic [4:0]  p2;
    logic [31:0] phase;
    logic        zero;
  } log_t;

  typedef struct packed {
    logic [30:0] r;
    logic [23:0] f;
    logic [5:0]  sh;
    logic        sat;
    logic        under;
    logic        zero;
    logic [31:0] phase;
  } exp_t;

  typedef struct packed {
    logic signed [ROT_W-1:0] x;
    logic signed [ROT_W-1:0] y;
    logic signed [ROT_W-1:0] z;
    logic                    flip;
    logic                    sat;
  } rot_t;

  // Integer square root, used only to build constant tables.
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] bit_v;
    rem  = v;
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      bit_v = 64'd1 << (2 * i);
      if (rem >= root + bit_v) begin
        rem  = rem - (root + bit_v);
        root = (root >> 1) + bit_v;
      end else begin
        root = root >> 1;
      end
    end
    return root;
  endfunction

  // Restoring long division, used only to build constant tables.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Successive square roots of 2.0 in Q1.30 for the exp2 chain.
  function automatic logic [EXP_CELLS:1][30:0] exp_roots();
    logic [63:0]                c;
    logic [EXP_CELLS:1][30:0]   tab;
    c   = 64'd1 << 31;
    tab = '0;
    for (int k = 1; k <= EXP_CELLS; k++) begin
      c      = isqrt64(c << 30);
      tab[k] = c[30:0];
    end
    return tab;
  endfunction

  // Rotation gain compensation in Q.30 for the configured number of steps.
  function automatic logic [30:0] rot_gain();
    logic [63:0] g;
    logic [63:0] f;
    g = 64'd1 << 30;
    for (int k = 0; k < STEPS_USED; k++) begin
      f = 64'd1 << 60;
      if (2 * k <= 60) f = f + (64'd1 << (60 - 2 * k));
      g = udiv64(g << 30, isqrt64(f));
    end
    return g[30:0];
  endfunction

  localparam logic [EXP_CELLS:1][30:0] EXP_ROOTS = exp_roots();
  localparam logic [30:0]              ROT_GAIN  = rot_gain();

endpackage

>>> rtl/scs_polar_cell.sv
// Polar cell: square-root digit for both inputs; vectoring rotation if step < STEPS_USED.
module scs_polar_cell import scs_pkg::*; (
  input  logic       clk,
  input  logic       en,
  input  logic [4:0] step,
  input  polar_t     d_i,
  output polar_t     q_o
);

  polar_t                  q_nxt;
  polar_t                  q_r;
  logic [5:0]              sq_sh;
  logic [63:0]             bit_v;
  logic [63:0]             try1;
  logic [63:0]             try2;
  logic signed [VEC_W-1:0] xs1;
  logic signed [VEC_W-1:0] ys1;
  logic signed [VEC_W-1:0] xs2;
  logic signed [VEC_W-1:0] ys2;

  always_comb begin
    q_nxt = d_i;
    sq_sh = 6'd62 - {step, 1'b0};
    bit_v = 64'd1 << sq_sh;
    try1  = d_i.root1 + bit_v;
    try2  = d_i.root2 + bit_v;
    if (d_i.rem1 >= try1) begin
      q_nxt.rem1  = d_i.rem1 - try1;
      q_nxt.root1 = (d_i.root1 >> 1) + bit_v;
    end else begin
      q_nxt.root1 = d_i.root1 >> 1;
    end
    if (d_i.rem2 >= try2) begin
      q_nxt.rem2  = d_i.rem2 - try2;
      q_nxt.root2 = (d_i.root2 >> 1) + bit_v;
    end else begin
      q_nxt.root2 = d_i.root2 >> 1;
    end

    xs1 = d_i.x1 >>> step;
    ys1 = d_i.y1 >>> step;
    xs2 = d_i.x2 >>> step;
    ys2 = d_i.y2 >>> step;
    if (int'(step) < STEPS_USED) begin
      // Drive the imaginary part toward zero; a zero imaginary part stops the angle.
      if (!d_i.y1[VEC_W-1] && (d_i.y1 != '0)) begin
        q_nxt.x1   = d_i.x1 + ys1;
        q_nxt.y1   = d_i.y1 - xs1;
        q_nxt.ang1 = d_i.ang1 + ATAN_TURNS[step];
      end else if (d_i.y1[VEC_W-1]) begin
        q_nxt.x1   = d_i.x1 - ys1;
        q_nxt.y1   = d_i.y1 + xs1;
        q_nxt.ang1 = d_i.ang1 - ATAN_TURNS[step];
      end
      if (!d_i.y2[VEC_W-1] && (d_i.y2 != '0)) begin
        q_nxt.x2   = d_i.x2 + ys2;
        q_nxt.y2   = d_i.y2 - xs2;
        q_nxt.ang2 = d_i.ang2 + ATAN_TURNS[step];
      end else if (d_i.y2[VEC_W-1]) begin
        q_nxt.x2   = d_i.x2 - ys2;
        q_nxt.y2   = d_i.y2 + xs2;
        q_nxt.ang2 = d_i.ang2 - ATAN_TURNS[step];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) q_r <= q_nxt;
  end

  assign q_o = q_r;

endmodule

>>> rtl/scs_log_cell.sv
// One cell of the log2 chain: squares both mantissas and yields one fraction bit each.
module scs_log_cell import scs_pkg::*; (
  input  logic clk,
  input  logic en,
  input  log_t d_i,
  output log_t q_o
);

  log_t        q_nxt;
  log_t        q_r;
  logic [61:0] sq1;
  logic [61:0] sq2;

  always_comb begin
    q_nxt = d_i;
    sq1   = d_i.m1 * d_i.m1;
    sq2   = d_i.m2 * d_i.m2;
    if (sq1[61]) begin
      q_nxt.m1    = sq1[61:31];
      q_nxt.frac1 = {d_i.frac1[22:0], 1'b1};
    end else begin
      q_nxt.m1    = sq1[60:30];
      q_nxt.frac1 = {d_i.frac1[22:0], 1'b0};
    end
    if (sq2[61]) begin
      q_nxt.m2    = sq2[61:31];
      q_nxt.frac2 = {d_i.frac2[22:0], 1'b1};
    end else begin
      q_nxt.m2    = sq2[60:30];
      q_nxt.frac2 = {d_i.frac2[22:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) q_r <= q_nxt;
  end

  assign q_o = q_r;

endmodule

>>> rtl/scs_exp_cell.sv
// One cell of the exp2 chain: multiplies by a root of two when its fraction bit is set.
module scs_exp_cell import scs_pkg::*; (
  input  logic       clk,
  input  logic       en,
  input  logic [4:0] step,
  input  exp_t       d_i,
  output exp_t       q_o
);

  exp_t        q_nxt;
  exp_t        q_r;
  logic [61:0] prod;
  logic [4:0]  bit_idx;

  always_comb begin
    q_nxt   = d_i;
    prod    = d_i.r * EXP_ROOTS[step];
    bit_idx = 5'(EXP_CELLS) - step;
    if (d_i.f[bit_idx]) q_nxt.r = prod[60:30];
  end

  always_ff @(posedge clk) begin
    if (en) q_r <= q_nxt;
  end

  assign q_o = q_r;

endmodule

>>> rtl/scs_rot_cell.sv
// One cell of the output rotation chain: one CORDIC rotation toward the target phase.
module scs_rot_cell import scs_pkg::*; (
  input  logic       clk,
  input  logic       en,
  input  logic [4:0] step,
  input  rot_t       d_i,
  output rot_t       q_o
);

  rot_t                    q_nxt;
  rot_t                    q_r;
  logic signed [ROT_W-1:0] xs;
  logic signed [ROT_W-1:0] ys;
  logic signed [ROT_W-1:0] at;

  always_comb begin
    q_nxt = d_i;
    xs    = d_i.x >>> step;
    ys    = d_i.y >>> step;
    at    = $signed({2'b00, ATAN_TURNS[step]});
    if (!d_i.z[ROT_W-1]) begin
      q_nxt.x = d_i.x - ys;
      q_nxt.y = d_i.y + xs;
      q_nxt.z = d_i.z - at;
    end else begin
      q_nxt.x = d_i.x + ys;
      q_nxt.y = d_i.y - xs;
      q_nxt.z = d_i.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (en) q_r <= q_nxt;
  end

  assign q_o = q_r;

endmodule

>>> rtl/spectral_cross_synthesis_bin_top.sv
// Top level of the spectral cross-synthesis bin: configuration, pipeline glue and cell chains.
//
//   Channel   Direction  Handshake              Payload
//   in_       input      in_valid / in_stall    in_item   (in_item_t)
//   out_      output     out_valid / out_stall  out_item  (out_item_t)
//   cfg_      input      cfg_we                 cfg_index, cfg_wdata
//
// The block takes one item per clock while the output is not stalled and returns one
// result per item. Most of its depth lies in the 32-cell square-root and vectoring
// chain and the two 24-cell log2 and exp2 chains. Reset is synchronous and active low;
// it clears the valid bits and sets the configuration registers to their reset values.
// The whole pipeline moves together: it advances whenever the output register is
// empty or being taken, so a stall on the output holds every stage and the input.
module spectral_cross_synthesis_bin_top import scs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_item,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  // Configuration registers.
  logic        inv_r;
  logic [13:0] expo_r;
  logic [30:0] thr_r;

  // Pipeline control.
  logic                  adv;
  logic [PIPE_DEPTH-1:0] vld_r;
  logic                  out_valid_r;
  out_item_t             out_item_r;
  out_item_t             out_item_nxt;

  // Front end: input capture, squares and vectoring setup, magnitude sums.
  in_item_t    s0_r;
  in_item_t    s0_nxt;
  logic [63:0] s1_sq_r   [0:3];
  logic [63:0] s1_sq_nxt [0:3];
  polar_t      s1_pol_r;
  polar_t      s1_pol_nxt;
  polar_t      s2_r;
  polar_t      s2_nxt;

  polar_t pol [0:POLAR_CELLS];
  polar_t pe;

  // Mode selection and log2 setup.
  logic [31:0] l0_u1_r, l0_u2_r, l0_u1_nxt, l0_u2_nxt;
  logic [31:0] l0_phase_r, l0_phase_nxt;
  logic        l0_zero_r, l0_zero_nxt;
  logic [30:0] thr_eff;
  logic [31:0] div_mag;
  logic [35:0] norm1, norm2;
  log_t        l1_r, l1_nxt;

  log_t lg [0:LOG_CELLS];
  log_t le;

  // Log combine, exponent scaling and exp2 setup.
  logic signed [29:0] lv1, lv2;
  logic signed [30:0] c0_lg_r, c0_lg_nxt;
  logic [31:0]        c0_phase_r;
  logic               c0_zero_r;
  logic signed [45:0] c1_prod;
  logic signed [32:0] c1_l_r;
  logic [31:0]        c1_phase_r;
  logic               c1_zero_r;
  logic signed [8:0]  e0_n;
  logic signed [8:0]  e0_sh;
  exp_t               e0_r, e0_nxt;

  exp_t ex [0:EXP_CELLS];
  exp_t xe;

  // Magnitude, gain and rotation setup.
  logic [30:0] e1_mag_r, e1_mag_nxt;
  logic        e1_sat_r;
  logic [31:0] e1_phase_r;
  logic [61:0] g_prod;
  logic        g_flip;
  logic [31:0] g_p2;
  rot_t        g0_r, g0_nxt;

  rot_t rt [0:STEPS_USED];
  rot_t re;

  logic signed [ROT_W-1:0] o_x, o_y;
  logic [32:0]             o_cx, o_cy;

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // Returns the leading-one position and the mantissa normalized to Q1.30.
  function automatic logic [35:0] log_norm(input logic [31:0] u);
    logic [4:0]  p;
    logic [31:0] m;
    p = '0;
    for (int i = 0; i < 32; i++) begin
      if (u[i]) p = 5'(i);
    end
    if (p >= 5'd30) m = u >> (p - 5'd30);
    else            m = u << (5'd30 - p);
    return {p, m[30:0]};
  endfunction

  // Clamps to 32 signed bits; the top bit of the result flags a clip.
  function automatic logic [32:0] clamp32(input logic signed [ROT_W-1:0] v);
    logic clip;
    clip = (v[ROT_W-1:31] != '0) && (v[ROT_W-1:31] != '1);
    if (!clip) return {1'b0, v[31:0]};
    return {1'b1, (v[ROT_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF)};
  endfunction

  // The pipeline advances when the output register can take a new result.
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r  <= 1'b0;
      expo_r <= EXPONENT_RESET;
      thr_r  <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INVERT_MODE:      inv_r  <= cfg_wdata[0];
        REG_MAG_EXPONENT:     expo_r <= cfg_wdata[13:0];
        REG_DIVIDE_THRESHOLD: thr_r  <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[PIPE_DEPTH-2:0], in_valid};
      out_valid_r <= vld_r[PIPE_DEPTH-1];
    end
  end

  // Stage 0: capture; edge bins have no imaginary part.
  always_comb begin
    s0_nxt = in_item;
    if (in_item.edge_bin) begin
      s0_nxt.first_imag  = '0;
      s0_nxt.second_imag = '0;
    end
  end

  // Stage 1: squared components and the half-plane fold ahead of vectoring.
  always_comb begin
    s1_sq_nxt[0] = abs32(s0_r.first_real) * abs32(s0_r.first_real);
    s1_sq_nxt[1] = abs32(s0_r.first_imag) * abs32(s0_r.first_imag);
    s1_sq_nxt[2] = abs32(s0_r.second_real) * abs32(s0_r.second_real);
    s1_sq_nxt[3] = abs32(s0_r.second_imag) * abs32(s0_r.second_imag);

    s1_pol_nxt       = '0;
    s1_pol_nxt.zero1 = (s0_r.first_real == '0) && (s0_r.first_imag == '0);
    s1_pol_nxt.zero2 = (s0_r.second_real == '0) && (s0_r.second_imag == '0);
    if (s0_r.first_real[31]) begin
      s1_pol_nxt.x1   = -(VEC_W'(s0_r.first_real));
      s1_pol_nxt.y1   = -(VEC_W'(s0_r.first_imag));
      s1_pol_nxt.ang1 = 32'h8000_0000;
    end else begin
      s1_pol_nxt.x1   = VEC_W'(s0_r.first_real);
      s1_pol_nxt.y1   = VEC_W'(s0_r.first_imag);
    end
    if (s0_r.second_real[31]) begin
      s1_pol_nxt.x2   = -(VEC_W'(s0_r.second_real));
      s1_pol_nxt.y2   = -(VEC_W'(s0_r.second_imag));
      s1_pol_nxt.ang2 = 32'h8000_0000;
    end else begin
      s1_pol_nxt.x2   = VEC_W'(s0_r.second_real);
      s1_pol_nxt.y2   = VEC_W'(s0_r.second_imag);
    end
  end

  // Stage 2: sums of squares seed the square-root remainders.
  always_comb begin
    s2_nxt      = s1_pol_r;
    s2_nxt.rem1 = s1_sq_r[0] + s1_sq_r[1];
    s2_nxt.rem2 = s1_sq_r[2] + s1_sq_r[3];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_r     <= s0_nxt;
      s1_sq_r  <= s1_sq_nxt;
      s1_pol_r <= s1_pol_nxt;
      s2_r     <= s2_nxt;
    end
  end

  assign pol[0] = s2_r;

  for (genvar k = 0; k < POLAR_CELLS; k++) begin : g_polar
    scs_polar_cell u_cell (
      .clk  (clk),
      .en   (adv),
      .step (5'(k)),
      .d_i  (pol[k]),
      .q_o  (pol[k+1])
    );
  end

  assign pe = pol[POLAR_CELLS];

  // Mode selection: pick the log operands, the zero case and the phase.
  always_comb begin
    thr_eff   = (thr_r == '0) ? THRESHOLD_DEFAULT : thr_r;
    div_mag   = (pe.root2[31:0] > {1'b0, thr_eff}) ? pe.root2[31:0] : {1'b0, thr_eff};
    l0_u1_nxt = pe.root1[31:0];
    l0_u2_nxt = inv_r ? div_mag : pe.root2[31:0];
    if (inv_r) begin
      l0_zero_nxt  = pe.zero1;
      l0_phase_nxt = (!pe.zero1 && !pe.zero2) ? (pe.ang2 - pe.ang1) : '0;
    end else begin
      l0_zero_nxt  = pe.zero1 | pe.zero2;
      l0_phase_nxt = l0_zero_nxt ? '0 : ('0 - (pe.ang1 + pe.ang2));
    end
  end

  // Normalize both log operands to Q1.30.
  always_comb begin
    norm1        = log_norm(l0_u1_r);
    norm2        = log_norm(l0_u2_r);
    l1_nxt       = '0;
    l1_nxt.p1    = norm1[35:31];
    l1_nxt.m1    = norm1[30:0];
    l1_nxt.p2    = norm2[35:31];
    l1_nxt.m2    = norm2[30:0];
    l1_nxt.phase = l0_phase_r;
    l1_nxt.zero  = l0_zero_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l0_u1_r    <= l0_u1_nxt;
      l0_u2_r    <= l0_u2_nxt;
      l0_phase_r <= l0_phase_nxt;
      l0_zero_r  <= l0_zero_nxt;
      l1_r       <= l1_nxt;
    end
  end

  assign lg[0] = l1_r;

  for (genvar k = 0; k < LOG_CELLS; k++) begin : g_log
    scs_log_cell u_cell (
      .clk (clk),
      .en  (adv),
      .d_i (lg[k]),
      .q_o (lg[k+1])
    );
  end

  assign le = lg[LOG_CELLS];

  // Each log2 is (msb - 16) in the integer bits over 24 fraction bits.
  always_comb begin
    lv1       = $signed({({1'b0, le.p1} - 6'd16), le.frac1});
    lv2       = $signed({({1'b0, le.p2} - 6'd16), le.frac2});
    c0_lg_nxt = inv_r ? (31'(lv1) - 31'(lv2)) : (31'(lv1) + 31'(lv2));
    c1_prod   = c0_lg_r * $signed({1'b0, expo_r});
  end

  // Split the scaled log into an integer shift and a fraction for exp2.
  always_comb begin
    e0_n         = c1_l_r[32:24];
    e0_sh        = 9'sd14 - e0_n;
    e0_nxt.r     = 31'h4000_0000;
    e0_nxt.f     = c1_l_r[23:0];
    e0_nxt.sh    = e0_sh[5:0];
    e0_nxt.sat   = !c1_zero_r && (e0_n >= 9'sd15);
    e0_nxt.under = e0_n <= -9'sd49;
    e0_nxt.zero  = c1_zero_r;
    e0_nxt.phase = c1_phase_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c0_lg_r    <= c0_lg_nxt;
      c0_phase_r <= le.phase;
      c0_zero_r  <= le.zero;
      c1_l_r     <= c1_prod[44:12];
      c1_phase_r <= c0_phase_r;
      c1_zero_r  <= c0_zero_r;
      e0_r       <= e0_nxt;
    end
  end

  assign ex[0] = e0_r;

  for (genvar k = 0; k < EXP_CELLS; k++) begin : g_exp
    scs_exp_cell u_cell (
      .clk  (clk),
      .en   (adv),
      .step (5'(k + 1)),
      .d_i  (ex[k]),
      .q_o  (ex[k+1])
    );
  end

  assign xe = ex[EXP_CELLS];

  // Final magnitude: zero case, overflow, underflow or the scaled exp2 mantissa.
  always_comb begin
    if (xe.zero)       e1_mag_nxt = (expo_r == '0) ? 31'd65536 : '0;
    else if (xe.sat)   e1_mag_nxt = 31'h7FFF_FFFF;
    else if (xe.under) e1_mag_nxt = '0;
    else               e1_mag_nxt = xe.r >> xe.sh;
  end

  // Gain compensation and folding the phase into the right half plane.
  always_comb begin
    g_prod      = e1_mag_r * ROT_GAIN;
    g_flip      = e1_phase_r[31] ^ e1_phase_r[30];
    g_p2        = {e1_phase_r[31] ^ g_flip, e1_phase_r[30:0]};
    g0_nxt.x    = $signed({2'b00, g_prod[61:30]});
    g0_nxt.y    = '0;
    g0_nxt.z    = ROT_W'($signed(g_p2));
    g0_nxt.flip = g_flip;
    g0_nxt.sat  = e1_sat_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e1_mag_r   <= e1_mag_nxt;
      e1_sat_r   <= xe.sat;
      e1_phase_r <= xe.phase;
      g0_r       <= g0_nxt;
    end
  end

  assign rt[0] = g0_r;

  for (genvar k = 0; k < STEPS_USED; k++) begin : g_rot
    scs_rot_cell u_cell (
      .clk  (clk),
      .en   (adv),
      .step (5'(k)),
      .d_i  (rt[k]),
      .q_o  (rt[k+1])
    );
  end

  assign re = rt[STEPS_USED];

  // Undo the fold, conjugate and clamp into the output register.
  always_comb begin
    o_x                    = re.flip ? -re.x : re.x;
    o_y                    = re.flip ? re.y : -re.y;
    o_cx                   = clamp32(o_x);
    o_cy                   = clamp32(o_y);
    out_item_nxt.out_real  = o_cx[31:0];
    out_item_nxt.out_imag  = o_cy[31:0];
    out_item_nxt.saturated = re.sat | o_cx[32] | o_cy[32];
  end

  always_ff @(posedge clk) begin
    if (adv) out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTHESIS
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid set right after reset");

  a_stall_freezes_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(vld_r))
    else $error("pipeline moved while the output was stalled");

  a_accept_enters_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld_r[0])
    else $error("accepted item missing from the first stage");

  a_last_stage_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[PIPE_DEPTH-1] && adv) |=> out_valid)
    else $error("result from the last stage did not reach the output");
`endif

endmodule

>>> tb/spectral_cross_synthesis_bin_top_tb.sv
// Self-checking testbench for the spectral cross-synthesis bin top level.
module spectral_cross_synthesis_bin_top_tb;
  import scs_pkg::*;

  // Scoreboard: it holds the register settings, predicts each bin's result and keeps the
  // results still in flight through the pipeline in order.
  class bin_scoreboard;
    bit              invert_on;
    bit [13:0]       exponent_q12;
    bit [30:0]       threshold_raw;
    out_item_t       pending_bins[$];
    int              mismatches;
    longint unsigned rot_comp;

    function new();
      longint unsigned f;
      invert_on     = 1'b0;
      exponent_q12  = EXPONENT_RESET;
      threshold_raw = THRESHOLD_RESET;
      mismatches    = 0;
      rot_comp      = 64'd1 << 30;
      for (int k = 0; k < STEPS_USED; k++) begin
        f = 64'd1 << 60;
        if (2 * k <= 60) f += 64'd1 << (60 - 2 * k);
        rot_comp = (rot_comp << 30) / int_root(f);
      end
    endfunction

    function longint unsigned int_root(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function longint unsigned modulus(longint a, longint b);
      longint unsigned ua;
      longint unsigned ub;
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      return int_root(ua * ua + ub * ub);
    endfunction

    function bit [31:0] vector_angle(longint a, longint b);
      bit [31:0] z;
      longint    xs;
      longint    ys;
      z = 0;
      if (a == 0 && b == 0) return 0;
      if (a < 0) begin
        a = -a;
        b = -b;
        z = 32'h80000000;
      end
      for (int k = 0; k < STEPS_USED; k++) begin
        xs = a >>> k;
        ys = b >>> k;
        if (b > 0) begin
          a += ys; b -= xs; z += ATAN_TURNS[k];
        end else if (b < 0) begin
          a -= ys; b += xs; z -= ATAN_TURNS[k];
        end
      end
      return z;
    endfunction

    // log2 of a positive Q16.16 value, returned in Q.24.
    function longint log2_24(longint unsigned v);
      int              p;
      longint unsigned m;
      longint unsigned frac;
      p = 63;
      frac = 0;
      while (p > 0 && !v[p]) p--;
      m = (p >= 30) ? (v >> (p - 30)) : (v << (30 - p));
      for (int k = 0; k < 24; k++) begin
        m = (m * m) >> 30;
        frac <<= 1;
        if (m >= (64'd1 << 31)) begin
          frac |= 1;
          m >>= 1;
        end
      end
      return longint'(p - 16) * (64'sd1 <<< 24) + longint'(frac);
    endfunction

    function longint unsigned exp2_24(longint l, inout bit sat);
      longint          n;
      longint unsigned f;
      longint unsigned r;
      longint unsigned c;
      n = l >>> 24;
      f = l - n * (64'sd1 <<< 24);
      r = 64'd1 << 30;
      c = 64'd1 << 31;
      if (n >= 15) begin
        sat = 1'b1;
        return 64'h7FFFFFFF;
      end
      if (14 - n >= 63) return 0;
      for (int k = 1; k <= 24; k++) begin
        c = int_root(c << 30);
        if (f[24 - k]) r = (r * c) >> 30;
      end
      r >>= (14 - n);
      if (r > 64'h7FFFFFFF) begin
        sat = 1'b1;
        r = 64'h7FFFFFFF;
      end
      return r;
    endfunction

    function bit [31:0] clip32(longint v, inout bit sat);
      if (v > 64'sd2147483647) begin
        sat = 1'b1; v = 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
        sat = 1'b1; v = -64'sd2147483648;
      end
      return v[31:0];
    endfunction

    function void set_reg(cfg_reg_t idx, bit [30:0] val);
      case (idx)
        REG_INVERT_MODE:      invert_on = val[0];
        REG_MAG_EXPONENT:     exponent_q12 = val[13:0];
        REG_DIVIDE_THRESHOLD: threshold_raw = val;
        default: ;
      endcase
    endfunction

    // Notes an accepted input bin and queues the result it must produce.
    function void note_bin(in_item_t it);
      longint          a1, b1, a2, b2, lg, x, y, z, xs, ys;
      longint unsigned m1, m2, mag, thr, d;
      bit [31:0]       phase, p2;
      bit              sat, zero, flip;
      out_item_t       res;
      a1 = it.first_real;
      b1 = it.first_imag;
      a2 = it.second_real;
      b2 = it.second_imag;
      phase = 0;
      sat = 1'b0;
      lg = 0;
      if (it.edge_bin) begin
        b1 = 0;
        b2 = 0;
      end
      m1 = modulus(a1, b1);
      m2 = modulus(a2, b2);
      if (invert_on) begin
        thr = (threshold_raw != 0) ? threshold_raw : THRESHOLD_DEFAULT;
        d = (m2 > thr) ? m2 : thr;
        zero = (m1 == 0);
        if (!zero) lg = log2_24(m1) - log2_24(d);
        if (m1 != 0 && m2 != 0) phase = vector_angle(a2, b2) - vector_angle(a1, b1);
      end else begin
        zero = (m1 == 0 || m2 == 0);
        if (!zero) begin
          lg = log2_24(m1) + log2_24(m2);
          phase = 32'd0 - (vector_angle(a1, b1) + vector_angle(a2, b2));
        end
      end
      if (zero) mag = (exponent_q12 != 0) ? 0 : 65536;
      else mag = exp2_24((lg * longint'(exponent_q12)) >>> 12, sat);

      // Fold the phase into the right half plane, rotate, then unfold.
      flip = (phase >= 32'h40000000 && phase < 32'hC0000000);
      p2 = flip ? phase - 32'h80000000 : phase;
      z = longint'(signed'(p2));
      x = longint'((mag * rot_comp) >> 30);
      y = 0;
      for (int k = 0; k < STEPS_USED; k++) begin
        xs = x >>> k;
        ys = y >>> k;
        if (z >= 0) begin
          x -= ys; y += xs; z -= longint'(ATAN_TURNS[k]);
        end else begin
          x += ys; y -= xs; z += longint'(ATAN_TURNS[k]);
        end
      end
      if (flip) begin
        x = -x;
        y = -y;
      end
      res.out_real  = clip32(x, sat);
      res.out_imag  = clip32(-y, sat);
      res.saturated = sat;
      pending_bins.push_back(res);
    endfunction

    // Checks one result against the oldest queued prediction.
    function void check_bin(out_item_t got);
      out_item_t want;
      if (pending_bins.size() == 0) begin
        $error("result with no pending bin: real %0d imag %0d", got.out_real, got.out_imag);
        mismatches++;
        return;
      end
      want = pending_bins.pop_front();
      if (got.out_real !== want.out_real) begin
        $error("out_real expected %0d actual %0d", want.out_real, got.out_real);
        mismatches++;
      end
      if (got.out_imag !== want.out_imag) begin
        $error("out_imag expected %0d actual %0d", want.out_imag, got.out_imag);
        mismatches++;
      end
      if (got.saturated !== want.saturated) begin
        $error("saturated expected %0b actual %0b", want.saturated, got.saturated);
        mismatches++;
      end
    endfunction
  endclass

  // The drain wait leaves margin above the depth of the pipeline.
  localparam int DRAIN_CYCLES = PIPE_DEPTH + 40;
  localparam int CYCLE_LIMIT  = 600000;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  in_item_t               in_item;
  logic                   out_valid;
  logic                   out_stall;
  out_item_t              out_item;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  bin_scoreboard board;
  int            cycle_count;
  bit            no_gaps;

  spectral_cross_synthesis_bin_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Gap lengths: usually none, sometimes a few cycles, rarely a long pause.
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (no_gaps || pick < 65) return 0;
    if (pick < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // The result side takes items while not stalled and draws a fresh stall pattern.
  int stall_left;
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_bin(out_item);
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_left = idle_len();
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // Any hang ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Sends one bin: an optional idle gap, then hold the item until it is taken.
  task automatic send_bin(in_item_t it);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_bin(it);
  endtask

  // Waits until every queued result has come back and the pipeline is empty.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_bins.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register writes happen only with the pipeline drained.
  task automatic write_reg(cfg_reg_t idx, bit [30:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    board.set_reg(idx, val);
    @(posedge clk);
  endtask

  function automatic in_item_t make_bin(int r1, int i1, int r2, int i2, bit eb);
    in_item_t it;
    it.first_real  = r1;
    it.first_imag  = i1;
    it.second_real = r2;
    it.second_imag = i2;
    it.edge_bin    = eb;
    return it;
  endfunction

  // One component: full range, a modest magnitude, or zero.
  function automatic int rand_part();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return $urandom;
    if (pick < 8) return int'($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000;
    if (pick < 9) return int'($urandom_range(0, 2048)) - 1024;
    return 0;
  endfunction

  // Directed bins: extremes, zero bins on either side, edge bins and tiny values.
  task automatic directed_bins();
    send_bin(make_bin(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0));
    send_bin(make_bin(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 1'b0));
    send_bin(make_bin(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 1'b1));
    send_bin(make_bin(0, 0, 32'h00010000, 32'h00020000, 1'b0));
    send_bin(make_bin(32'h00010000, 32'hFFFF0000, 0, 0, 1'b0));
    send_bin(make_bin(0, 0, 0, 0, 1'b0));
    send_bin(make_bin(0, 32'h00050000, 0, 32'h00030000, 1'b1));
    send_bin(make_bin(32'hFFFF0000, 32'h1234, 32'h00030000, 32'h77777, 1'b1));
    send_bin(make_bin(1, 0, 1, 0, 1'b0));
    send_bin(make_bin(-1, -1, 0, 1, 1'b0));
    send_bin(make_bin(32'h00010000, 0, 32'h00010000, 0, 1'b0));
    send_bin(make_bin(32'h00100000, 32'h00100000, 100, 0, 1'b0));
    send_bin(make_bin(0, 32'hFFF00000, 32'h00000200, 32'hFFFFFE00, 1'b0));
  endtask

  task automatic random_bins(int count);
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) begin
        // Hold the sender off until the block has nothing left in flight.
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending_bins.size() != 0) @(posedge clk);
      end
      no_gaps = ($urandom_range(0, 19) == 0) ? ~no_gaps : no_gaps;
      send_bin(make_bin(rand_part(), rand_part(), rand_part(), rand_part(),
                        $urandom_range(0, 4) == 0));
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    board       = new();
    cycle_count = 0;
    stall_left  = 0;
    no_gaps     = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_item     = '0;
    out_stall   = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = REG_INVERT_MODE;
    cfg_wdata   = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings first: multiply mode with a quarter-power exponent.
    directed_bins();
    random_bins(80);
    drain();

    // Invert with unit exponent and the zero threshold that stands for 0.1.
    write_reg(REG_INVERT_MODE, 31'd1);
    write_reg(REG_MAG_EXPONENT, 31'd4096);
    write_reg(REG_DIVIDE_THRESHOLD, 31'd0);
    directed_bins();
    random_bins(80);
    drain();

    // Multiply with exponent zero, so every magnitude becomes one.
    write_reg(REG_INVERT_MODE, 31'd0);
    write_reg(REG_MAG_EXPONENT, 31'd0);
    write_reg(REG_DIVIDE_THRESHOLD, 31'h7FFFFFFF);
    directed_bins();
    random_bins(60);
    drain();

    // Invert with the largest threshold and the largest exponent.
    write_reg(REG_INVERT_MODE, 31'd1);
    write_reg(REG_MAG_EXPONENT, 31'd16383);
    directed_bins();
    random_bins(60);
    drain();

    // Multiply with the largest exponent; saturation is common here.
    write_reg(REG_INVERT_MODE, 31'd0);
    directed_bins();
    random_bins(60);
    drain();

    // Random settings to close out the run.
    for (int ph = 0; ph < 3; ph++) begin
      write_reg(REG_INVERT_MODE, 31'($urandom_range(0, 1)));
      write_reg(REG_MAG_EXPONENT, 31'($urandom_range(0, 16383)));
      write_reg(REG_DIVIDE_THRESHOLD, 31'($urandom_range(0, 32'h000FFFFF)));
      random_bins(40);
      drain();
    end

    if (board.mismatches == 0 && board.pending_bins.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/scs_pkg.sv
rtl/scs_polar_cell.sv
rtl/scs_log_cell.sv
rtl/scs_exp_cell.sv
rtl/scs_rot_cell.sv
rtl/spectral_cross_synthesis_bin_top.sv
tb/spectral_cross_synthesis_bin_top_tb.sv
